/* rtl/core/perspective_correct_color_interp_macros.svh */
`ifndef PERSPECTIVE_CORRECT_COLOR_INTERP_MACROS_SVH
`define PERSPECTIVE_CORRECT_COLOR_INTERP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define PCCI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define PCCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pcci_pkg.sv */
`timescale 1ns / 1ps

package pcci_pkg;

    typedef enum logic [2:0] {
        REG_DEPTH_A = 3'd0,
        REG_DEPTH_B = 3'd1,
        REG_DEPTH_C = 3'd2,
        REG_RGBA_A  = 3'd3,
        REG_RGBA_B  = 3'd4,
        REG_RGBA_C  = 3'd5,
        REG_LIGHT   = 3'd6
    } t_reg_idx;

    localparam int NUM_VERTS       = 3;
    localparam int NUM_CH          = 4;
    localparam int DEPTH_W         = 32;
    localparam int LIGHT_W         = 9;
    localparam int LIGHT_REG_W     = 27;
    localparam int LIGHT_ONE_SHIFT = 8;
    localparam int INV_BASE        = 52;

    localparam logic [DEPTH_W-1:0]     DEPTH_RESET = 32'h0001_0000;
    localparam logic [LIGHT_REG_W-1:0] LIGHT_RESET = 27'h402_0100;

endpackage

/* rtl/core/perspective_correct_color_interp.sv */
`timescale 1ns / 1ps
// Perspective-correct colour interpolation, one pixel word per clock while not stalled. Each
// word of three barycentric weights is divided by the vertex depths, blended over RGBA and
// the light factor, divided by the inverse depth and lit. The pipeline depth is set by the
// two restoring dividers, which retire one quotient bit per pipeline stage. A new word is
// taken every cycle while o_ready is high; a one-word skid at the output holds a result
// while the pipeline freezes. Registers sit at byte address 4*i (8*i when a colour register
// exceeds 32 bits).
`include "perspective_correct_color_interp_macros.svh"

module perspective_correct_color_interp #(
    parameter int COLOR_BITS  = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [((4*COLOR_BITS > 32) ? 6 : 5)-1:0]  paddr,
    input  logic [((4*COLOR_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((4*COLOR_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic                                      pready,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [WEIGHT_BITS-1:0]                    i_weight_a,
    input  logic [WEIGHT_BITS-1:0]                    i_weight_b,
    input  logic [WEIGHT_BITS-1:0]                    i_weight_c,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [COLOR_BITS-1:0]                     o_red_out,
    output logic [COLOR_BITS-1:0]                     o_green_out,
    output logic [COLOR_BITS-1:0]                     o_blue_out,
    output logic [COLOR_BITS-1:0]                     o_alpha_out,
    output logic                                      o_zero_weight_flag
);

    import pcci_pkg::*;

    localparam int DW     = (4*COLOR_BITS > 32) ? 64 : 32;
    localparam int ASH    = (DW == 64) ? 3 : 2;
    localparam int AW     = ASH + 3;
    localparam int RGBA_W = 4*COLOR_BITS;
    localparam int SH     = INV_BASE - WEIGHT_BITS - COLOR_BITS;
    localparam int NQ     = WEIGHT_BITS + SH;
    localparam int DB     = (COLOR_BITS > LIGHT_W) ? COLOR_BITS : LIGHT_W;
    localparam int SW     = NQ + 2;
    localparam int PW     = DB + NQ;
    localparam int NW     = PW + 2;
    localparam int LANES  = NUM_CH + 1;
    localparam int LIT_W  = COLOR_BITS + LIGHT_W;
    localparam logic [COLOR_BITS-1:0] CH_MAX = '1;

    // configuration
    logic [DEPTH_W-1:0]     r_depth [NUM_VERTS];
    logic [RGBA_W-1:0]      r_rgba  [NUM_VERTS];
    logic [LIGHT_REG_W-1:0] r_light;
    logic                   cfg_wr;
    t_reg_idx               cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[AW-1:ASH]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VERTS; v++) begin
                r_depth[v] <= DEPTH_RESET;
                r_rgba[v]  <= '0;
            end
            r_light <= LIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEPTH_A: r_depth[0] <= pwdata[DEPTH_W-1:0];
                REG_DEPTH_B: r_depth[1] <= pwdata[DEPTH_W-1:0];
                REG_DEPTH_C: r_depth[2] <= pwdata[DEPTH_W-1:0];
                REG_RGBA_A:  r_rgba[0]  <= pwdata[RGBA_W-1:0];
                REG_RGBA_B:  r_rgba[1]  <= pwdata[RGBA_W-1:0];
                REG_RGBA_C:  r_rgba[2]  <= pwdata[RGBA_W-1:0];
                REG_LIGHT:   r_light    <= pwdata[LIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DEPTH_A: prdata = DW'(r_depth[0]);
            REG_DEPTH_B: prdata = DW'(r_depth[1]);
            REG_DEPTH_C: prdata = DW'(r_depth[2]);
            REG_RGBA_A:  prdata = DW'(r_rgba[0]);
            REG_RGBA_B:  prdata = DW'(r_rgba[1]);
            REG_RGBA_C:  prdata = DW'(r_rgba[2]);
            REG_LIGHT:   prdata = DW'(r_light);
            default:     prdata = '0;
        endcase
    end

    // pipeline enable
    logic en;
    logic r_skid_v;

    assign en      = !r_skid_v;
    assign o_ready = en;

    // inverse depth terms
    logic [WEIGHT_BITS-1:0] w      [NUM_VERTS];
    logic [NQ:0]            d1_num [NUM_VERTS];
    logic [DEPTH_W-1:0]     d1_den [NUM_VERTS];
    logic [NQ-1:0]          d1_quo [NUM_VERTS];
    logic                   d1_v;

    assign w[0] = i_weight_a;
    assign w[1] = i_weight_b;
    assign w[2] = i_weight_c;

    always_comb begin
        for (int v = 0; v < NUM_VERTS; v++) begin
            d1_num[v] = {1'b0, w[v], {SH{1'b0}}};
            d1_den[v] = (r_depth[v] == '0) ? DEPTH_W'(1) : r_depth[v];
        end
    end

    pcci_div_pipe #(
        .LANES (NUM_VERTS),
        .NUM_W (NQ + 1),
        .DEN_W (DEPTH_W),
        .Q_W   (NQ)
    ) u_inv_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .o_valid (d1_v),
        .o_quo   (d1_quo)
    );

    // weighted products
    logic [DB-1:0] coef [LANES][NUM_VERTS];

    always_comb begin
        for (int v = 0; v < NUM_VERTS; v++) begin
            for (int k = 0; k < NUM_CH; k++) begin
                coef[k][v] = DB'(r_rgba[v][(NUM_CH-1-k)*COLOR_BITS +: COLOR_BITS]);
            end
            coef[NUM_CH][v] = DB'(r_light[v*LIGHT_W +: LIGHT_W]);
        end
    end

    logic          r_p1_v;
    logic [SW-1:0] r_sum;
    logic [PW-1:0] r_prod [LANES][NUM_VERTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (en) begin
            r_p1_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= SW'(d1_quo[0]) + SW'(d1_quo[1]) + SW'(d1_quo[2]);
            for (int k = 0; k < LANES; k++) begin
                for (int v = 0; v < NUM_VERTS; v++) begin
                    r_prod[k][v] <= PW'(coef[k][v]) * PW'(d1_quo[v]);
                end
            end
        end
    end

    // numerators
    logic          r_p2_v;
    logic [NW-1:0] r_num [LANES];
    logic [SW-1:0] r_den;
    logic          r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (en) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < LANES; k++) begin
                r_num[k] <= NW'(r_prod[k][0]) + NW'(r_prod[k][1]) + NW'(r_prod[k][2]);
            end
            r_den  <= r_sum;
            r_zero <= (r_sum == '0);
        end
    end

    // normalise by inverse depth
    logic [SW-1:0] d2_den [LANES];
    logic [DB-1:0] d2_quo [LANES];
    logic          d2_v;
    logic [DB:0]   r_zl;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            d2_den[k] = r_den;
        end
    end

    pcci_div_pipe #(
        .LANES (LANES),
        .NUM_W (NW),
        .DEN_W (SW),
        .Q_W   (DB)
    ) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p2_v),
        .i_num   (r_num),
        .i_den   (d2_den),
        .o_valid (d2_v),
        .o_quo   (d2_quo)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zl <= {r_zl[DB-1:0], r_zero};
        end
    end

    // clamp
    logic                  r_l_v;
    logic [COLOR_BITS-1:0] r_l_ch [NUM_CH];
    logic [LIGHT_W-1:0]    r_l_light;
    logic                  r_l_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_v <= 1'b0;
        end else if (en) begin
            r_l_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_l_ch[k] <= (d2_quo[k] > DB'(CH_MAX)) ? CH_MAX : d2_quo[k][COLOR_BITS-1:0];
            end
            r_l_light <= d2_quo[NUM_CH][LIGHT_W-1:0];
            r_l_zero  <= r_zl[DB];
        end
    end

    // light and output register
    logic [LIT_W-1:0]           n_lit   [NUM_CH-1];
    logic [LIT_W-LIGHT_ONE_SHIFT-1:0] n_scl [NUM_CH-1];
    logic [COLOR_BITS-1:0]      n_ch    [NUM_CH];

    always_comb begin
        for (int k = 0; k < NUM_CH - 1; k++) begin
            n_lit[k] = LIT_W'(r_l_ch[k]) * LIT_W'(r_l_light);
            n_scl[k] = n_lit[k][LIT_W-1:LIGHT_ONE_SHIFT];
            n_ch[k]  = (n_scl[k] > (LIT_W-LIGHT_ONE_SHIFT)'(CH_MAX)) ?
                       CH_MAX : n_scl[k][COLOR_BITS-1:0];
            if (r_l_zero) begin
                n_ch[k] = '0;
            end
        end
        n_ch[NUM_CH-1] = r_l_zero ? '0 : r_l_ch[NUM_CH-1];
    end

    logic                  r_out_v;
    logic [COLOR_BITS-1:0] r_out_ch [NUM_CH];
    logic                  r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_l_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_ch   <= n_ch;
            r_out_zero <= r_l_zero;
        end
    end

    // skid: hold the stalled word while the output register takes the next word
    logic [COLOR_BITS-1:0] r_skid_ch [NUM_CH];
    logic                  r_skid_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_out_v && !i_ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && r_out_v && !i_ready) begin
            r_skid_ch   <= r_out_ch;
            r_skid_zero <= r_out_zero;
        end
    end

    assign o_valid            = r_skid_v | r_out_v;
    assign o_red_out          = r_skid_v ? r_skid_ch[0] : r_out_ch[0];
    assign o_green_out        = r_skid_v ? r_skid_ch[1] : r_out_ch[1];
    assign o_blue_out         = r_skid_v ? r_skid_ch[2] : r_out_ch[2];
    assign o_alpha_out        = r_skid_v ? r_skid_ch[3] : r_out_ch[3];
    assign o_zero_weight_flag = r_skid_v ? r_skid_zero : r_out_zero;

    `PCCI_ASSERT_SAME(a_skid_fill, $rose(r_skid_v), $past(r_out_v && !i_ready), "skid filled without a stalled word")
    `PCCI_ASSERT_SAME(a_zero_black, o_valid && o_zero_weight_flag, o_red_out == '0 && o_green_out == '0 && o_blue_out == '0 && o_alpha_out == '0, "zero weight word carries colour")
    `PCCI_ASSERT_NEXT(a_freeze, r_skid_v && !i_ready, r_skid_v && $stable(r_out_v), "pipeline moved while skid held")

endmodule

/* rtl/core/pcci_div_pipe.sv */
`timescale 1ns / 1ps

module pcci_div_pipe #(
    parameter int LANES = 3,
    parameter int NUM_W = 45,
    parameter int DEN_W = 32,
    parameter int Q_W   = 44
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num [LANES],
    input  logic [DEN_W-1:0] i_den [LANES],
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo [LANES]
);

    logic [Q_W:0]     r_v;
    logic [DEN_W-1:0] r_rem [Q_W+1][LANES];
    logic [Q_W-1:0]   r_low [Q_W+1][LANES];
    logic [DEN_W-1:0] r_den [Q_W+1][LANES];
    logic [Q_W-1:0]   r_quo [Q_W+1][LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Q_W-1:0], i_valid};
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][l] <= DEN_W'(i_num[l][NUM_W-1:Q_W]);
                r_low[0][l] <= i_num[l][Q_W-1:0];
                r_den[0][l] <= i_den[l];
                r_quo[0][l] <= '0;
            end
        end

        for (genvar s = 1; s <= Q_W; s++) begin : g_step
            logic [DEN_W:0]   trial;
            logic             ge;
            logic [DEN_W:0]   diff;
            logic [DEN_W-1:0] n_rem;

            always_comb begin
                trial = {r_rem[s-1][l], r_low[s-1][l][Q_W-1]};
                diff  = trial - {1'b0, r_den[s-1][l]};
                ge    = (trial >= {1'b0, r_den[s-1][l]});
                n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][l] <= n_rem;
                    r_low[s][l] <= {r_low[s-1][l][Q_W-2:0], 1'b0};
                    r_den[s][l] <= r_den[s-1][l];
                    r_quo[s][l] <= {r_quo[s-1][l][Q_W-2:0], ge};
                end
            end
        end

        assign o_quo[l] = r_quo[Q_W][l];
    end

    assign o_valid = r_v[Q_W];

endmodule
